FILE: hw/rtl/gme_pkg.sv
// Package for the modular Gaussian elimination block.
// Holds the request and result structs, the action codes and the register indexes.
// No dependencies.
package gme_pkg;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_RUN   = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;
  localparam logic [1:0] ACT_NOP   = 2'd3;

  localparam logic [2:0] REG_ROW_COUNT   = 3'd0;
  localparam logic [2:0] REG_COL_COUNT   = 3'd1;
  localparam logic [2:0] REG_PIVOT_COLS  = 3'd2;
  localparam logic [2:0] REG_REDUCE_MODE = 3'd3;
  localparam logic [2:0] REG_MODULUS     = 3'd4;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [30:0] value;
  } gme_req_t;

  typedef struct packed {
    logic [30:0] read_value;
    logic [4:0]  rank;
    logic [30:0] determinant;
  } gme_res_t;

  // Command to the modular multiplier: a must be below m, b may be any value.
  typedef struct packed {
    logic        start;
    logic [30:0] a;
    logic [30:0] b;
    logic [30:0] m;
  } gme_mul_cmd_t;

endpackage

FILE: hw/rtl/modular_gauss_elimination.sv
// Modular Gaussian elimination over a prime field with a MAX_ROWS x MAX_COLS entry store.
// A write reduces its value through the multiplier before storing it; a read returns the stored entry.
// A run reduces every entry, then per pivot column searches, swaps rows, inverts the pivot and eliminates.
// One item at a time (req_ready is high only in idle); the bit-serial multiplier sets the rate.
// Reset clears control state, rank (0) and determinant (1); the store is not cleared.
module modular_gauss_elimination import gme_pkg::*; #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  gme_req_t    req_data,
  output logic        res_valid,
  input  logic        res_ready,
  output gme_res_t    res_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CW    = $clog2(MAX_COLS + 1);

  // Sequencer state codes.
  localparam logic [5:0] S_IDLE      = 6'd0;
  localparam logic [5:0] S_WR_WAIT   = 6'd1;
  localparam logic [5:0] S_RD_ISSUE  = 6'd2;
  localparam logic [5:0] S_RD_CAP    = 6'd3;
  localparam logic [5:0] S_OUT       = 6'd4;
  localparam logic [5:0] S_RUN_INIT  = 6'd5;
  localparam logic [5:0] S_RED_RD    = 6'd6;
  localparam logic [5:0] S_RED_MUL   = 6'd7;
  localparam logic [5:0] S_RED_WAIT  = 6'd8;
  localparam logic [5:0] S_COL       = 6'd9;
  localparam logic [5:0] S_SRCH_RD   = 6'd10;
  localparam logic [5:0] S_SRCH_CHK  = 6'd11;
  localparam logic [5:0] S_SW_RA     = 6'd12;
  localparam logic [5:0] S_SW_RB     = 6'd13;
  localparam logic [5:0] S_SW_WA     = 6'd14;
  localparam logic [5:0] S_SW_WB     = 6'd15;
  localparam logic [5:0] S_PIV_RD    = 6'd16;
  localparam logic [5:0] S_PIV_CAP   = 6'd17;
  localparam logic [5:0] S_DET_WAIT  = 6'd18;
  localparam logic [5:0] S_POW_STEP  = 6'd19;
  localparam logic [5:0] S_POW_MR    = 6'd20;
  localparam logic [5:0] S_POW_SQ    = 6'd21;
  localparam logic [5:0] S_POW_SW    = 6'd22;
  localparam logic [5:0] S_NRM_RD    = 6'd23;
  localparam logic [5:0] S_NRM_MUL   = 6'd24;
  localparam logic [5:0] S_NRM_WAIT  = 6'd25;
  localparam logic [5:0] S_PIV2_RD   = 6'd26;
  localparam logic [5:0] S_PIV2_CAP  = 6'd27;
  localparam logic [5:0] S_EL_INIT   = 6'd28;
  localparam logic [5:0] S_EL_ROW    = 6'd29;
  localparam logic [5:0] S_EL_CHK    = 6'd30;
  localparam logic [5:0] S_EL_CW     = 6'd31;
  localparam logic [5:0] S_EL_RA     = 6'd32;
  localparam logic [5:0] S_EL_MUL    = 6'd33;
  localparam logic [5:0] S_EL_MW     = 6'd34;
  localparam logic [5:0] S_EL_WR     = 6'd35;

  // Configuration registers.
  logic [4:0]  row_count;
  logic [4:0]  col_count;
  logic [4:0]  pivot_cols;
  logic        reduce_mode;
  logic [30:0] modulus;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count   <= 5'd16;
      col_count   <= 5'd16;
      pivot_cols  <= 5'd16;
      reduce_mode <= 1'b0;
      modulus     <= 31'd998244353;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_COUNT:   row_count   <= cfg_data[4:0];
        REG_COL_COUNT:   col_count   <= cfg_data[4:0];
        REG_PIVOT_COLS:  pivot_cols  <= cfg_data[4:0];
        REG_REDUCE_MODE: reduce_mode <= cfg_data[0];
        REG_MODULUS:     modulus     <= cfg_data;
        default: ;
      endcase
    end
  end

  // A modulus below two behaves as two.
  logic [30:0] meff;
  assign meff = (modulus < 31'd2) ? 31'd2 : modulus;

  // The matrix store: one address per cycle, registered read data.
  logic [30:0] mem [DEPTH];
  logic [AW-1:0] addr;
  logic          mem_we;
  logic [30:0]   mem_wdata;
  logic [30:0]   rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= mem_wdata;
    end
    rdata <= mem[addr];
  end

  // Sequencer registers.
  logic [5:0]    state;
  logic [5:0]    state_next;
  gme_req_t      req;
  logic [RW-1:0] h;
  logic [CW-1:0] w;
  logic [CW-1:0] pe;
  logic [RW-1:0] i;
  logic [RW-1:0] p;
  logic [RW-1:0] rank;
  logic [CW-1:0] j;
  logic [CW-1:0] k;
  logic [RW-1:0] rank_reg;
  logic [30:0]   det_reg;
  logic [30:0]   det;
  logic [30:0]   piv;
  logic [30:0]   tmp;
  logic [30:0]   coef;
  logic [30:0]   sub;
  logic [30:0]   pr;
  logic [30:0]   pb;
  logic [30:0]   ex;
  logic [4:0]    ecnt;
  logic          second;
  logic [30:0]   rv;

  gme_mul_cmd_t  mul_cmd;
  logic          mul_done;
  logic [30:0]   mul_res;

  gme_modmul u_mul (
    .clk    (clk),
    .rst    (rst),
    .cmd    (mul_cmd),
    .done   (mul_done),
    .result (mul_res)
  );

  logic          req_inside;
  logic [AW-1:0] req_addr;
  logic [RW-1:0] arow;
  logic [CW-1:0] acol;
  logic          use_req_addr;
  logic [31:0]   diff;

  assign req_inside = (int'(req.row) < MAX_ROWS) && (int'(req.col) < MAX_COLS);
  assign req_addr   = AW'(int'(req.row) * MAX_COLS + int'(req.col));
  assign req_ready  = (state == S_IDLE);

  // Subtraction mod m of the product from the entry held in rdata.
  assign diff = (rdata >= sub) ? {1'b0, rdata - sub}
                               : ({1'b0, rdata} + {1'b0, meff} - {1'b0, sub});

  // Address, write and multiplier selection per state.
  always_comb begin
    use_req_addr = 1'b0;
    arow         = i;
    acol         = k;
    mem_we       = 1'b0;
    mem_wdata    = mul_res;
    mul_cmd      = '0;
    mul_cmd.m    = meff;
    case (state)
      S_IDLE: begin
        // The write of a new element starts its reduction on acceptance.
        mul_cmd.start = req_valid && (req_data.action == ACT_WRITE);
        mul_cmd.a     = 31'd1;
        mul_cmd.b     = req_data.value;
      end
      S_WR_WAIT: begin
        use_req_addr = 1'b1;
        mem_we       = mul_done && req_inside;
      end
      S_RD_ISSUE, S_RD_CAP: use_req_addr = 1'b1;
      S_RED_MUL: begin
        mul_cmd.start = 1'b1;
        mul_cmd.a     = 31'd1;
        mul_cmd.b     = rdata;
      end
      S_RED_WAIT: mem_we = mul_done;
      S_SRCH_RD, S_SRCH_CHK: acol = j;
      S_SW_RA: arow = rank;
      S_SW_RB: arow = p;
      S_SW_WA: begin
        arow      = rank;
        mem_we    = 1'b1;
        mem_wdata = rdata;
      end
      S_SW_WB: begin
        arow      = p;
        mem_we    = 1'b1;
        mem_wdata = tmp;
      end
      S_PIV_RD, S_PIV_CAP, S_PIV2_RD, S_PIV2_CAP: begin
        arow = rank;
        acol = j;
        if (state == S_PIV_CAP) begin
          mul_cmd.start = 1'b1;
          mul_cmd.a     = det;
          mul_cmd.b     = rdata;
        end
      end
      S_POW_STEP: begin
        mul_cmd.start = ex[0];
        mul_cmd.a     = pr;
        mul_cmd.b     = pb;
      end
      S_POW_SQ: begin
        mul_cmd.start = 1'b1;
        mul_cmd.a     = pb;
        mul_cmd.b     = pb;
      end
      S_NRM_RD: arow = rank;
      S_NRM_MUL: begin
        arow          = rank;
        mul_cmd.start = 1'b1;
        mul_cmd.a     = rdata;
        mul_cmd.b     = pr;
      end
      S_NRM_WAIT: begin
        arow   = rank;
        mem_we = mul_done;
      end
      S_EL_ROW, S_EL_CHK: begin
        acol = j;
        if (state == S_EL_CHK) begin
          mul_cmd.start = (rdata != 31'd0);
          mul_cmd.a     = rdata;
          mul_cmd.b     = pr;
        end
      end
      S_EL_RA: arow = rank;
      S_EL_MUL: begin
        arow          = rank;
        mul_cmd.start = 1'b1;
        mul_cmd.a     = rdata;
        mul_cmd.b     = coef;
      end
      S_EL_WR: begin
        mem_we    = 1'b1;
        mem_wdata = diff[30:0];
      end
      default: ;
    endcase
    addr = use_req_addr ? req_addr : AW'(int'(arow) * MAX_COLS + int'(acol));
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          case (req_data.action)
            ACT_WRITE: state_next = S_WR_WAIT;
            ACT_RUN:   state_next = S_RUN_INIT;
            ACT_READ:  state_next = S_RD_ISSUE;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_WR_WAIT:  if (mul_done) state_next = S_IDLE;
      S_RD_ISSUE: state_next = S_RD_CAP;
      S_RD_CAP:   state_next = S_OUT;
      S_OUT:      if (!res_valid || res_ready) state_next = S_IDLE;
      S_RUN_INIT: begin
        if (row_count == 5'd0 || col_count == 5'd0) begin
          state_next = S_OUT;
        end else begin
          state_next = S_RED_RD;
        end
      end
      S_RED_RD:   state_next = S_RED_MUL;
      S_RED_MUL:  state_next = S_RED_WAIT;
      S_RED_WAIT: begin
        if (mul_done) begin
          if (k == w - CW'(1) && i == h - RW'(1)) begin
            state_next = S_COL;
          end else begin
            state_next = S_RED_RD;
          end
        end
      end
      S_COL: begin
        if (j == pe) begin
          state_next = S_OUT;
        end else if (rank != h) begin
          state_next = S_SRCH_RD;
        end
      end
      S_SRCH_RD: state_next = S_SRCH_CHK;
      S_SRCH_CHK: begin
        if (rdata != 31'd0) begin
          state_next = (i != rank) ? S_SW_RA : S_PIV_RD;
        end else if (i == h - RW'(1)) begin
          state_next = S_COL;
        end else begin
          state_next = S_SRCH_RD;
        end
      end
      S_SW_RA: state_next = S_SW_RB;
      S_SW_RB: state_next = S_SW_WA;
      S_SW_WA: state_next = S_SW_WB;
      S_SW_WB: state_next = (k == w - CW'(1)) ? S_PIV_RD : S_SW_RA;
      S_PIV_RD:   state_next = S_PIV_CAP;
      S_PIV_CAP:  state_next = S_DET_WAIT;
      S_DET_WAIT: if (mul_done) state_next = S_POW_STEP;
      S_POW_STEP: state_next = ex[0] ? S_POW_MR : S_POW_SQ;
      S_POW_MR:   if (mul_done) state_next = S_POW_SQ;
      S_POW_SQ:   state_next = S_POW_SW;
      S_POW_SW: begin
        if (mul_done) begin
          if (ecnt != 5'd30) begin
            state_next = S_POW_STEP;
          end else if (!second && reduce_mode && piv != 31'd1) begin
            state_next = S_NRM_RD;
          end else begin
            state_next = S_EL_INIT;
          end
        end
      end
      S_NRM_RD:   state_next = S_NRM_MUL;
      S_NRM_MUL:  state_next = S_NRM_WAIT;
      S_NRM_WAIT: begin
        if (mul_done) begin
          state_next = (k == w - CW'(1)) ? S_PIV2_RD : S_NRM_RD;
        end
      end
      S_PIV2_RD:  state_next = S_PIV2_CAP;
      S_PIV2_CAP: state_next = S_POW_STEP;
      S_EL_INIT:  state_next = S_EL_ROW;
      S_EL_ROW: begin
        if (i >= h) begin
          state_next = S_COL;
        end else if (i != rank) begin
          state_next = S_EL_CHK;
        end
      end
      S_EL_CHK:  state_next = (rdata != 31'd0) ? S_EL_CW : S_EL_ROW;
      S_EL_CW:   if (mul_done) state_next = S_EL_RA;
      S_EL_RA:   state_next = S_EL_MUL;
      S_EL_MUL:  state_next = S_EL_MW;
      S_EL_MW:   if (mul_done) state_next = S_EL_WR;
      S_EL_WR:   state_next = (k == w - CW'(1)) ? S_EL_ROW : S_EL_RA;
      default:   state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      rank_reg  <= '0;
      det_reg   <= 31'd1;
    end else begin
      state <= state_next;
      if (state == S_OUT && (!res_valid || res_ready)) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if (state == S_RUN_INIT && (row_count == 5'd0 || col_count == 5'd0)) begin
        rank_reg <= '0;
        det_reg  <= 31'd1;
      end
      if (state == S_COL && j == pe) begin
        rank_reg <= rank;
        det_reg  <= det;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == S_OUT && (!res_valid || res_ready)) begin
      res_data.read_value  <= rv;
      res_data.rank        <= 5'(rank_reg);
      res_data.determinant <= det_reg;
    end
    case (state)
      S_IDLE: begin
        req <= req_data;
        rv  <= 31'd0;
      end
      S_RD_CAP: rv <= req_inside ? rdata : 31'd0;
      S_RUN_INIT: begin
        h  <= (int'(row_count) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(row_count);
        w  <= (int'(col_count) > MAX_COLS) ? CW'(MAX_COLS) : CW'(col_count);
        pe <= (int'(pivot_cols) > MAX_COLS || pivot_cols > col_count)
              ? ((int'(col_count) > MAX_COLS) ? CW'(MAX_COLS) : CW'(col_count))
              : CW'(pivot_cols);
        i    <= '0;
        k    <= '0;
        j    <= '0;
        rank <= '0;
        det  <= 31'd1;
      end
      S_RED_WAIT: begin
        if (mul_done) begin
          if (k == w - CW'(1)) begin
            k <= '0;
            i <= i + RW'(1);
          end else begin
            k <= k + CW'(1);
          end
        end
      end
      S_COL: begin
        i <= rank;
        if (j != pe && rank == h) begin
          det <= 31'd0;
          j   <= j + CW'(1);
        end
      end
      S_SRCH_CHK: begin
        if (rdata != 31'd0) begin
          p <= i;
          k <= '0;
          if (i != rank) begin
            det <= (det == 31'd0) ? 31'd0 : meff - det;
          end
        end else if (i == h - RW'(1)) begin
          det <= 31'd0;
          j   <= j + CW'(1);
        end else begin
          i <= i + RW'(1);
        end
      end
      S_SW_RB: tmp <= rdata;
      S_SW_WB: k <= k + CW'(1);
      S_PIV_CAP: begin
        piv    <= rdata;
        pb     <= rdata;
        pr     <= 31'd1;
        ex     <= meff - 31'd2;
        ecnt   <= '0;
        second <= 1'b0;
      end
      S_DET_WAIT: if (mul_done) det <= mul_res;
      S_POW_MR:   if (mul_done) pr <= mul_res;
      S_POW_SW: begin
        if (mul_done) begin
          pb   <= mul_res;
          ex   <= {1'b0, ex[30:1]};
          ecnt <= ecnt + 5'd1;
          k    <= j;
        end
      end
      S_NRM_WAIT: if (mul_done) k <= k + CW'(1);
      S_PIV2_CAP: begin
        pb     <= rdata;
        pr     <= 31'd1;
        ex     <= meff - 31'd2;
        ecnt   <= '0;
        second <= 1'b1;
      end
      S_EL_INIT: i <= reduce_mode ? RW'(0) : rank + RW'(1);
      S_EL_ROW: begin
        if (i >= h) begin
          rank <= rank + RW'(1);
          j    <= j + CW'(1);
        end else if (i == rank) begin
          i <= i + RW'(1);
        end
      end
      S_EL_CHK: if (rdata == 31'd0) i <= i + RW'(1);
      S_EL_CW: begin
        if (mul_done) begin
          coef <= mul_res;
          k    <= j;
        end
      end
      S_EL_MW: if (mul_done) sub <= mul_res;
      S_EL_WR: begin
        if (k == w - CW'(1)) begin
          i <= i + RW'(1);
        end else begin
          k <= k + CW'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/gme_modmul.sv
// Bit-serial modular multiplier: result = (a * b) mod m, one bit of b per cycle.
// Depends on gme_pkg for the command struct.
module gme_modmul import gme_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  gme_mul_cmd_t cmd,
  output logic         done,
  output logic [30:0]  result
);

  logic [30:0] a;
  logic [30:0] m;
  logic [30:0] bsh;
  logic [4:0]  cnt;
  logic        busy;
  logic [32:0] t;
  logic [32:0] m1;
  logic [32:0] m2;
  logic [32:0] t_red;

  // Horner step: 2r + bit*a stays below 3m since r and a are below m.
  always_comb begin
    t  = {1'b0, result, 1'b0} + {2'b00, (bsh[30] ? a : 31'd0)};
    m1 = {2'b00, m};
    m2 = {1'b0, m, 1'b0};
    if (t >= m2) begin
      t_red = t - m2;
    end else if (t >= m1) begin
      t_red = t - m1;
    end else begin
      t_red = t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= 5'd31;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      result <= '0;
      a      <= cmd.a;
      m      <= cmd.m;
      bsh    <= cmd.b;
    end else if (busy) begin
      result <= t_red[30:0];
      bsh    <= {bsh[29:0], 1'b0};
    end
  end

endmodule
